// File: rtl/core/mexp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared word width, counter width, register indexes and reset values for
// the modular exponentiation block.
// ----------------------------------------------------------------------------
package mexp_pkg;

    // arithmetic word and data field width
    localparam int WORD_BITS = 16;
    // bit counter for one serial pass over a word
    localparam int CNT_W     = $clog2(WORD_BITS);
    // configuration register index width
    localparam int CFG_IDX_W = 1;

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [CNT_W-1:0]     bit_cnt_t;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 1'b1;

    // register reset values
    localparam word_t EXPONENT_RESET = word_t'(1);
    localparam word_t MODULUS_RESET  = word_t'(65535);

    // last count of a serial pass
    localparam bit_cnt_t CNT_LAST = bit_cnt_t'(WORD_BITS - 1);

endpackage : mexp_pkg
`default_nettype wire

// File: rtl/core/mexp_reduce.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mexp_reduce
// Bit-serial restoring reduction: value mod m, one dividend bit per cycle,
// most significant bit first. Pulses done after the last bit is shifted in.
// ----------------------------------------------------------------------------
module mexp_reduce (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  start,
    input  wire mexp_pkg::word_t value,
    input  wire mexp_pkg::word_t m,
    output logic                 done,
    output mexp_pkg::word_t      remainder
);
    import mexp_pkg::*;

    logic       busy_reg;
    logic       done_reg;
    bit_cnt_t   cnt_reg;
    word_t      val_reg;
    word_t      rem_reg;
    word_t      rem_next;
    logic [WORD_BITS:0] trial;

    // shift in next dividend bit, subtract modulus when it fits
    always_comb
    begin
        trial = {rem_reg, val_reg[WORD_BITS-1]};
        if (trial >= {1'b0, m})
        begin
            trial = trial - {1'b0, m};
        end
        rem_next = trial[WORD_BITS-1:0];
    end

    // pass sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            val_reg  <= '0;
            rem_reg  <= '0;
        end
        else
        begin
            // pulse after the last step of a pass
            done_reg <= !start && busy_reg && (cnt_reg == CNT_LAST);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                val_reg  <= value;
                rem_reg  <= '0;
            end
            else if (busy_reg)
            begin
                rem_reg <= rem_next;
                val_reg <= {val_reg[WORD_BITS-2:0], 1'b0};
                cnt_reg <= cnt_reg + bit_cnt_t'(1);
                if (cnt_reg == CNT_LAST)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule : mexp_reduce
`default_nettype wire

// File: rtl/core/mexp_modmul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mexp_modmul
// Bit-serial modular multiplier: a * b mod m for a, b < m. Scans b from its
// low bit, adding and doubling a with a modular add each cycle. After the
// last bit of b it pulses done.
// ----------------------------------------------------------------------------
module mexp_modmul (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  start,
    input  wire mexp_pkg::word_t a,
    input  wire mexp_pkg::word_t b,
    input  wire mexp_pkg::word_t m,
    output logic                 done,
    output mexp_pkg::word_t      product
);
    import mexp_pkg::*;

    logic     busy_reg;
    logic     done_reg;
    bit_cnt_t cnt_reg;
    word_t    a_reg;
    word_t    b_reg;
    word_t    acc_reg;
    word_t    acc_next;
    word_t    a_next;
    logic [WORD_BITS:0] acc_sum;
    logic [WORD_BITS:0] dbl_sum;

    // modular add into accumulator and modular doubling of a
    always_comb
    begin
        acc_sum = {1'b0, acc_reg} + {1'b0, a_reg};
        if (acc_sum >= {1'b0, m})
        begin
            acc_sum = acc_sum - {1'b0, m};
        end
        dbl_sum = {a_reg, 1'b0};
        if (dbl_sum >= {1'b0, m})
        begin
            dbl_sum = dbl_sum - {1'b0, m};
        end
        acc_next = b_reg[0] ? acc_sum[WORD_BITS-1:0] : acc_reg;
        a_next   = dbl_sum[WORD_BITS-1:0];
    end

    // pass sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            a_reg    <= '0;
            b_reg    <= '0;
            acc_reg  <= '0;
        end
        else
        begin
            // pulse after the last step of a pass
            done_reg <= !start && busy_reg && (cnt_reg == CNT_LAST);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                a_reg    <= a;
                b_reg    <= b;
                acc_reg  <= '0;
            end
            else if (busy_reg)
            begin
                acc_reg <= acc_next;
                a_reg   <= a_next;
                b_reg   <= {1'b0, b_reg[WORD_BITS-1:1]};
                cnt_reg <= cnt_reg + bit_cnt_t'(1);
                if (cnt_reg == CNT_LAST)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule : mexp_modmul
`default_nettype wire

// File: rtl/core/modular_exponentiation.sv
`default_nettype none
// ----------------------------------------------------------------------------
// modular_exponentiation
// Computes base_value ^ exponent mod modulus per request with right-to-left
// square and multiply over bit-serial modular arithmetic.
// ----------------------------------------------------------------------------
// Each request returns one result. The base is first reduced modulo the
// modulus in a serial pass; then each exponent bit, from the low bit up to
// the highest set bit, takes an issue step and a pass of the two serial
// multipliers, which form the multiply and the square side by side, after
// which the products are taken. An exponent of zero (result 1, checked
// first) or a modulus of 0 or 1 (result 0) skips the serial passes.
// One request is worked on at a time; a new one is taken while the previous
// result waits in the output register. Configuration is to be written by
// the user only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module modular_exponentiation (
    input  wire                              clk,
    input  wire                              rst_n,
    // configuration write port
    input  wire                              cfg_wr_en,
    input  wire [mexp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire mexp_pkg::word_t             cfg_data,
    // request stream
    input  wire                              s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire [15:0]                       s_axis_tdata,  // [15:0] base_value
    // result stream
    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    output logic [15:0]                      m_axis_tdata   // [15:0] power_result
);
    import mexp_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_STEP,
        ST_MULT,
        ST_FINISH
    } state_t;

    state_t state_reg;
    word_t  exponent_reg;
    word_t  modulus_reg;
    word_t  exp_reg;
    word_t  m_reg;
    word_t  base_reg;
    word_t  acc_reg;
    word_t  res_reg;
    logic   out_valid_reg;
    word_t  out_data_reg;

    logic   in_accept;
    logic   out_free;
    logic   red_start;
    logic   red_done;
    word_t  red_rem;
    logic   mul_start;
    logic   mul_done;
    logic   sqr_done;
    word_t  mul_prod;
    word_t  sqr_prod;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exponent_reg <= EXPONENT_RESET;
            modulus_reg  <= MODULUS_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_EXPONENT: exponent_reg <= cfg_data;
                REG_MODULUS:  modulus_reg  <= cfg_data;
                default:      ;
            endcase
        end
    end

    // handshakes and unit starts
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign red_start = in_accept && (exponent_reg != '0) && (modulus_reg > word_t'(1));
    assign mul_start = (state_reg == ST_STEP) && (exp_reg != '0);

    // serial base reduction
    mexp_reduce u_reduce (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (red_start),
        .value     (word_t'(s_axis_tdata)),
        .m         (modulus_reg),
        .done      (red_done),
        .remainder (red_rem)
    );

    // multiply: result times base
    mexp_modmul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (acc_reg),
        .b       (base_reg),
        .m       (m_reg),
        .done    (mul_done),
        .product (mul_prod)
    );

    // square: base times base
    mexp_modmul u_sqr (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (base_reg),
        .b       (base_reg),
        .m       (m_reg),
        .done    (sqr_done),
        .product (sqr_prod)
    );

    // exponent sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            exp_reg       <= '0;
            m_reg         <= '0;
            base_reg      <= '0;
            acc_reg       <= '0;
            res_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            // result taken; a finishing request reloads the register below
            if (out_valid_reg && m_axis_tready && (state_reg != ST_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        exp_reg <= exponent_reg;
                        m_reg   <= modulus_reg;
                        acc_reg <= word_t'(1);
                        if (exponent_reg == '0)
                        begin
                            res_reg   <= word_t'(1);
                            state_reg <= ST_FINISH;
                        end
                        else if (modulus_reg <= word_t'(1))
                        begin
                            res_reg   <= '0;
                            state_reg <= ST_FINISH;
                        end
                        else
                        begin
                            state_reg <= ST_REDUCE;
                        end
                    end
                end
                ST_REDUCE:
                begin
                    if (red_done)
                    begin
                        base_reg  <= red_rem;
                        state_reg <= ST_STEP;
                    end
                end
                ST_STEP:
                begin
                    // no set bits left: result is final
                    if (exp_reg == '0)
                    begin
                        res_reg   <= acc_reg;
                        state_reg <= ST_FINISH;
                    end
                    else
                    begin
                        state_reg <= ST_MULT;
                    end
                end
                ST_MULT:
                begin
                    if (sqr_done)
                    begin
                        if (exp_reg[0])
                        begin
                            acc_reg <= mul_prod;
                        end
                        base_reg  <= sqr_prod;
                        exp_reg   <= {1'b0, exp_reg[WORD_BITS-1:1]};
                        state_reg <= ST_STEP;
                    end
                end
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= res_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = 16'(out_data_reg);

    // both multipliers run in lockstep
    a_mul_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done == sqr_done)
        else $error("multiply and square units out of step");

    // reduction finishes only while the sequencer waits for it
    a_red_state: assert property (@(posedge clk) disable iff (!rst_n)
        red_done |-> (state_reg == ST_REDUCE))
        else $error("reduction done outside reduce state");

    // operands stay reduced below the modulus
    a_operands_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STEP) |-> (acc_reg < m_reg) && (base_reg < m_reg))
        else $error("operand not reduced modulo modulus");

    // an accepted request always leaves idle
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg != ST_IDLE))
        else $error("request accepted but sequencer stayed idle");

    // a result is loaded only when the output register is free
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH) && out_valid_reg && !m_axis_tready
        |=> (state_reg == ST_FINISH))
        else $error("pending result overwritten");

endmodule : modular_exponentiation
`default_nettype wire
